// ===== design/htc_pkg.sv =====
`timescale 1ns / 1ps

// Shared types, constants and command encodings of the temperature and
// humidity compensator.
package htc_pkg;

  // Field and arithmetic widths.
  localparam int RAW_W     = 16;
  localparam int SQ_W      = 2 * RAW_W;
  localparam int REG_W     = 48;
  localparam int VAL_W     = 28;
  localparam int DIGIT_W   = 32;
  localparam int MOP_W     = DIGIT_W + 1;
  localparam int PROD_W    = 2 * MOP_W;
  localparam int ACC_W     = 120;
  localparam int DT_W      = REG_W + 1;
  localparam int F_W       = 64;
  localparam int STEP_W    = 4;

  // Lowest accumulator bit of each of the two output values.
  localparam int TEMP_VAL_LSB = 16;
  localparam int RH_VAL_LSB   = 48;

  // Configuration port.
  localparam int APB_AW    = 6;
  localparam int APB_DW    = 64;
  localparam int IDX_LSB   = 3;

  typedef logic signed [REG_W-1:0]  reg_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [MOP_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DT_W-1:0]   dt_t;
  typedef logic signed [VAL_W-1:0]  value_t;
  typedef logic [STEP_W-1:0]        step_t;

  // Saturation limits.
  localparam reg_t   REG_MAX = {1'b0, {(REG_W-1){1'b1}}};
  localparam reg_t   REG_MIN = {1'b1, {(REG_W-1){1'b0}}};
  localparam value_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Reference temperature of 25 degrees in Q16.32.
  localparam dt_t TEMP_REF_Q32 = dt_t'(64'd25 << DIGIT_W);

  // Last sequencer step of each conversion.
  localparam step_t TEMP_LAST_STEP = 4'd2;
  localparam step_t HUM_LAST_STEP  = 4'd11;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_TEMP_OFFSET   = 3'd0,
    REG_TEMP_GAIN     = 3'd1,
    REG_RH_OFFSET     = 3'd2,
    REG_RH_LINEAR     = 3'd3,
    REG_RH_SQUARE     = 3'd4,
    REG_RH_TEMP_BASE  = 3'd5,
    REG_RH_TEMP_SLOPE = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [REG_W-1:0] temp_offset;
    logic signed [REG_W-1:0] temp_gain;
    logic signed [REG_W-1:0] rh_offset;
    logic signed [REG_W-1:0] rh_linear;
    logic signed [REG_W-1:0] rh_square;
    logic signed [REG_W-1:0] rh_temp_base;
    logic signed [REG_W-1:0] rh_temp_slope;
  } cfg_t;

  // Result codes.
  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_VALUE = 2'd1,
    STAT_ACK   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TEMP = 2'd1,
    KIND_RH   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_TEMP = 2'd1,
    CMD_RH   = 2'd2
  } command_e;

  // Measurement phase kept between polls.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TEMP = 2'd1,
    PH_HUM  = 2'd2
  } phase_e;

  // Kind of work one poll causes.
  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_INIT = 2'd1,
    JOB_TEMP = 2'd2,
    JOB_HUM  = 2'd3
  } job_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_TEMP = 2'd1,
    ST_HUM  = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  // Multiplier operand selects.
  typedef enum logic [3:0] {
    A_R1_LO = 4'd0,
    A_R1_HI = 4'd1,
    A_R3_LO = 4'd2,
    A_R3_HI = 4'd3,
    A_R4_LO = 4'd4,
    A_R4_HI = 4'd5,
    A_R6_LO = 4'd6,
    A_R6_HI = 4'd7,
    A_DT_LO = 4'd8,
    A_DT_HI = 4'd9
  } a_sel_e;

  typedef enum logic [1:0] {
    B_RAW  = 2'd0,
    B_SQ   = 2'd1,
    B_F_LO = 2'd2,
    B_F_HI = 2'd3
  } b_sel_e;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } shift_e;

  typedef enum logic [1:0] {
    LD_NONE         = 2'd0,
    LD_TEMP_OFFSET  = 2'd1,
    LD_RH_TEMP_BASE = 2'd2,
    LD_RH_OFFSET    = 2'd3
  } load_e;

  typedef enum logic [1:0] {
    VAL_ZERO = 2'd0,
    VAL_TEMP = 2'd1,
    VAL_RH   = 2'd2
  } value_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_load;
    logic       mul_en;
    a_sel_e     a_sel;
    b_sel_e     b_sel;
    shift_e     shift;
    load_e      acc_load;
    logic       f_capture;
    logic       dt_load;
    logic       lt_load;
    logic       out_load;
    value_sel_e value_sel;
    status_e    status;
    kind_e      kind;
    command_e   command;
  } dp_cmd_t;

endpackage

// ===== design/htc_regs.sv =====
`timescale 1ns / 1ps

// Coefficient register file behind the APB-style configuration port.
module htc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [htc_pkg::APB_AW-1:0]   paddr,
  input  logic [htc_pkg::APB_DW-1:0]   pwdata,
  output logic [htc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output htc_pkg::cfg_t                cfg_o
);

  htc_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;
  htc_pkg::reg_t wr_val;
  htc_pkg::reg_t rd_val;

  assign pready = 1'b1;
  assign idx    = paddr[htc_pkg::APB_AW-1:htc_pkg::IDX_LSB];
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_val = htc_pkg::reg_t'(pwdata[htc_pkg::REG_W-1:0]);

  // Register writes; an address beyond the last register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        htc_pkg::REG_TEMP_OFFSET:   cfg_q.temp_offset   <= wr_val;
        htc_pkg::REG_TEMP_GAIN:     cfg_q.temp_gain     <= wr_val;
        htc_pkg::REG_RH_OFFSET:     cfg_q.rh_offset     <= wr_val;
        htc_pkg::REG_RH_LINEAR:     cfg_q.rh_linear     <= wr_val;
        htc_pkg::REG_RH_SQUARE:     cfg_q.rh_square     <= wr_val;
        htc_pkg::REG_RH_TEMP_BASE:  cfg_q.rh_temp_base  <= wr_val;
        htc_pkg::REG_RH_TEMP_SLOPE: cfg_q.rh_temp_slope <= wr_val;
        default: begin
        end
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    unique case (idx)
      htc_pkg::REG_TEMP_OFFSET:   rd_val = cfg_q.temp_offset;
      htc_pkg::REG_TEMP_GAIN:     rd_val = cfg_q.temp_gain;
      htc_pkg::REG_RH_OFFSET:     rd_val = cfg_q.rh_offset;
      htc_pkg::REG_RH_LINEAR:     rd_val = cfg_q.rh_linear;
      htc_pkg::REG_RH_SQUARE:     rd_val = cfg_q.rh_square;
      htc_pkg::REG_RH_TEMP_BASE:  rd_val = cfg_q.rh_temp_base;
      htc_pkg::REG_RH_TEMP_SLOPE: rd_val = cfg_q.rh_temp_slope;
      default:                    rd_val = '0;
    endcase
  end

  assign prdata = {{(htc_pkg::APB_DW-htc_pkg::REG_W){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

endmodule

// ===== design/htc_dp.sv =====
`timescale 1ns / 1ps

// Datapath: one shared 33 x 33 signed multiplier with a registered product,
// a 120-bit accumulator and the saturating output stage.
module htc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  htc_pkg::cfg_t               cfg_i,
  input  htc_pkg::dp_cmd_t            cmd_i,
  input  logic [htc_pkg::RAW_W-1:0]   raw_reading_i,
  output logic [1:0]                  status_o,
  output logic signed [htc_pkg::VAL_W-1:0] value_o,
  output logic [1:0]                  value_kind_o,
  output logic [1:0]                  command_o
);

  localparam int ACC_W   = htc_pkg::ACC_W;
  localparam int REG_W   = htc_pkg::REG_W;
  localparam int VAL_W   = htc_pkg::VAL_W;
  localparam int DIGIT_W = htc_pkg::DIGIT_W;
  localparam int RAW_W   = htc_pkg::RAW_W;
  localparam int T_LSB   = htc_pkg::TEMP_VAL_LSB;
  localparam int H_LSB   = htc_pkg::RH_VAL_LSB;

  logic [RAW_W-1:0]         raw_q;
  logic [htc_pkg::SQ_W-1:0] sq_q;
  htc_pkg::mop_t            a_op;
  htc_pkg::mop_t            b_op;
  htc_pkg::prod_t           prod_d;
  htc_pkg::prod_t           prod_q;
  logic                     pv_q;
  htc_pkg::shift_e          psh_q;
  htc_pkg::acc_t            acc_q;
  htc_pkg::acc_t            acc_d;
  htc_pkg::acc_t            addend;
  htc_pkg::acc_t            load_val;
  logic [htc_pkg::F_W-1:0]  f_q;
  htc_pkg::dt_t             dt_q;
  htc_pkg::reg_t            lt_q;
  htc_pkg::reg_t            lt_sat;
  htc_pkg::value_t          temp_val;
  htc_pkg::value_t          rh_val;
  htc_pkg::value_t          value_d;
  htc_pkg::value_t          value_q;
  htc_pkg::status_e         status_q;
  htc_pkg::kind_e           kind_q;
  htc_pkg::command_e        command_q;
  logic                     lt_fits;
  logic                     temp_fits;
  logic                     rh_fits;

  // Multiplier operand A: low digits are unsigned, top digits carry the sign.
  always_comb begin
    unique case (cmd_i.a_sel)
      htc_pkg::A_R1_LO: a_op = htc_pkg::mop_t'({1'b0, cfg_i.temp_gain[DIGIT_W-1:0]});
      htc_pkg::A_R1_HI: a_op = htc_pkg::mop_t'($signed(cfg_i.temp_gain[REG_W-1:DIGIT_W]));
      htc_pkg::A_R3_LO: a_op = htc_pkg::mop_t'({1'b0, cfg_i.rh_linear[DIGIT_W-1:0]});
      htc_pkg::A_R3_HI: a_op = htc_pkg::mop_t'($signed(cfg_i.rh_linear[REG_W-1:DIGIT_W]));
      htc_pkg::A_R4_LO: a_op = htc_pkg::mop_t'({1'b0, cfg_i.rh_square[DIGIT_W-1:0]});
      htc_pkg::A_R4_HI: a_op = htc_pkg::mop_t'($signed(cfg_i.rh_square[REG_W-1:DIGIT_W]));
      htc_pkg::A_R6_LO: a_op = htc_pkg::mop_t'({1'b0, cfg_i.rh_temp_slope[DIGIT_W-1:0]});
      htc_pkg::A_R6_HI: begin
        a_op = htc_pkg::mop_t'($signed(cfg_i.rh_temp_slope[REG_W-1:DIGIT_W]));
      end
      htc_pkg::A_DT_LO: a_op = htc_pkg::mop_t'({1'b0, dt_q[DIGIT_W-1:0]});
      htc_pkg::A_DT_HI: a_op = htc_pkg::mop_t'($signed(dt_q[htc_pkg::DT_W-1:DIGIT_W]));
      default:          a_op = '0;
    endcase
  end

  // Multiplier operand B.
  always_comb begin
    unique case (cmd_i.b_sel)
      htc_pkg::B_RAW:  b_op = htc_pkg::mop_t'({{(htc_pkg::MOP_W-RAW_W){1'b0}}, raw_q});
      htc_pkg::B_SQ:   b_op = htc_pkg::mop_t'({1'b0, sq_q});
      htc_pkg::B_F_LO: b_op = htc_pkg::mop_t'({1'b0, f_q[DIGIT_W-1:0]});
      htc_pkg::B_F_HI: b_op = htc_pkg::mop_t'($signed(f_q[htc_pkg::F_W-1:DIGIT_W]));
      default:         b_op = '0;
    endcase
  end

  assign prod_d = a_op * b_op;

  // Align the registered product to its digit position.
  always_comb begin
    unique case (psh_q)
      htc_pkg::SH_0:  addend = htc_pkg::acc_t'(prod_q);
      htc_pkg::SH_32: addend = htc_pkg::acc_t'(prod_q) <<< DIGIT_W;
      htc_pkg::SH_64: addend = htc_pkg::acc_t'(prod_q) <<< (2 * DIGIT_W);
      default:        addend = htc_pkg::acc_t'(prod_q);
    endcase
  end

  // Starting value of each sum; the humidity polynomial is kept 32 bits up.
  always_comb begin
    unique case (cmd_i.acc_load)
      htc_pkg::LD_TEMP_OFFSET:  load_val = htc_pkg::acc_t'(cfg_i.temp_offset);
      htc_pkg::LD_RH_TEMP_BASE: load_val = htc_pkg::acc_t'(cfg_i.rh_temp_base);
      htc_pkg::LD_RH_OFFSET:    load_val = htc_pkg::acc_t'(cfg_i.rh_offset) <<< DIGIT_W;
      default:                  load_val = '0;
    endcase
  end

  // Accumulator next value.
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_load != htc_pkg::LD_NONE) begin
      acc_d = load_val;
    end else if (pv_q) begin
      acc_d = acc_q + addend;
    end
  end

  // Saturation of the stored temperature and of both output values.
  assign lt_fits   = (&acc_q[ACC_W-1:REG_W-1]) | ~(|acc_q[ACC_W-1:REG_W-1]);
  assign temp_fits = (&acc_q[ACC_W-1:T_LSB+VAL_W-1]) | ~(|acc_q[ACC_W-1:T_LSB+VAL_W-1]);
  assign rh_fits   = (&acc_q[ACC_W-1:H_LSB+VAL_W-1]) | ~(|acc_q[ACC_W-1:H_LSB+VAL_W-1]);

  always_comb begin
    if (lt_fits) begin
      lt_sat = acc_q[REG_W-1:0];
    end else begin
      lt_sat = acc_q[ACC_W-1] ? htc_pkg::REG_MIN : htc_pkg::REG_MAX;
    end
    if (temp_fits) begin
      temp_val = acc_q[T_LSB+VAL_W-1:T_LSB];
    end else begin
      temp_val = acc_q[ACC_W-1] ? htc_pkg::VAL_MIN : htc_pkg::VAL_MAX;
    end
    if (rh_fits) begin
      rh_val = acc_q[H_LSB+VAL_W-1:H_LSB];
    end else begin
      rh_val = acc_q[ACC_W-1] ? htc_pkg::VAL_MIN : htc_pkg::VAL_MAX;
    end
  end

  always_comb begin
    unique case (cmd_i.value_sel)
      htc_pkg::VAL_TEMP: value_d = temp_val;
      htc_pkg::VAL_RH:   value_d = rh_val;
      default:           value_d = '0;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      lt_q <= '0;
    end else begin
      pv_q <= cmd_i.mul_en;
      if (cmd_i.lt_load) begin
        lt_q <= lt_sat;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      raw_q <= raw_reading_i;
      sq_q  <= {{RAW_W{1'b0}}, raw_reading_i} * {{RAW_W{1'b0}}, raw_reading_i};
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      psh_q  <= cmd_i.shift;
    end
    acc_q <= acc_d;
    if (cmd_i.f_capture) begin
      f_q <= acc_q[htc_pkg::F_W-1:0];
    end
    if (cmd_i.dt_load) begin
      dt_q <= htc_pkg::dt_t'(lt_q) - htc_pkg::TEMP_REF_Q32;
    end
    if (cmd_i.out_load) begin
      value_q   <= value_d;
      status_q  <= cmd_i.status;
      kind_q    <= cmd_i.kind;
      command_q <= cmd_i.command;
    end
  end

  assign status_o     = status_q;
  assign value_o      = value_q;
  assign value_kind_o = kind_q;
  assign command_o    = command_q;

`ifndef ASSERT_OFF
  // A new sum must never start while a product is still to be added.
  a_load_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc_load != htc_pkg::LD_NONE) |-> !pv_q)
    else $error("accumulator load collides with a pending product");
`endif

endmodule

// ===== design/htc_ctrl.sv =====
`timescale 1ns / 1ps

// Controller: measurement phase, poll decoding, multiply sequencer and the
// output valid flag.
module htc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              ready_req_i,
  input  logic              ack_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output htc_pkg::dp_cmd_t  cmd_o
);

  htc_pkg::state_e state_q, state_d;
  htc_pkg::step_t  step_q, step_d;
  htc_pkg::job_e   job_q, job_d;
  htc_pkg::phase_e phase_q, phase_d;
  logic            ack_q, ack_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    job_d       = job_q;
    phase_d     = phase_q;
    ack_d       = ack_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      htc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ack_d  = ack_i;
          step_d = '0;
          unique case (phase_q)
            htc_pkg::PH_TEMP: begin
              job_d   = ready_req_i ? htc_pkg::JOB_TEMP : htc_pkg::JOB_NONE;
              state_d = ready_req_i ? htc_pkg::ST_TEMP : htc_pkg::ST_DONE;
            end
            htc_pkg::PH_HUM: begin
              job_d   = ready_req_i ? htc_pkg::JOB_HUM : htc_pkg::JOB_NONE;
              state_d = ready_req_i ? htc_pkg::ST_HUM : htc_pkg::ST_DONE;
            end
            default: begin
              job_d   = htc_pkg::JOB_INIT;
              state_d = htc_pkg::ST_DONE;
            end
          endcase
        end
      end
      htc_pkg::ST_TEMP: begin
        step_d = step_q + 1'b1;
        if (step_q == htc_pkg::TEMP_LAST_STEP) begin
          state_d = htc_pkg::ST_DONE;
        end
      end
      htc_pkg::ST_HUM: begin
        step_d = step_q + 1'b1;
        if (step_q == htc_pkg::HUM_LAST_STEP) begin
          state_d = htc_pkg::ST_DONE;
        end
      end
      htc_pkg::ST_DONE: begin
        if (slot_free) begin
          state_d     = htc_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          unique case (job_q)
            htc_pkg::JOB_INIT: phase_d = htc_pkg::PH_TEMP;
            htc_pkg::JOB_TEMP: phase_d = htc_pkg::PH_HUM;
            htc_pkg::JOB_HUM:  phase_d = htc_pkg::PH_TEMP;
            default:           phase_d = phase_q;
          endcase
        end
      end
      default: state_d = htc_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      htc_pkg::ST_IDLE: begin
        cmd_o.in_load = in_valid_i;
      end
      htc_pkg::ST_TEMP: begin
        unique case (step_q)
          4'd0: begin
            cmd_o.acc_load = htc_pkg::LD_TEMP_OFFSET;
            cmd_o.mul_en   = 1'b1;
            cmd_o.a_sel    = htc_pkg::A_R1_LO;
            cmd_o.b_sel    = htc_pkg::B_RAW;
            cmd_o.shift    = htc_pkg::SH_0;
          end
          4'd1: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_R1_HI;
            cmd_o.b_sel  = htc_pkg::B_RAW;
            cmd_o.shift  = htc_pkg::SH_32;
          end
          default: begin
          end
        endcase
      end
      htc_pkg::ST_HUM: begin
        unique case (step_q)
          // Compensation factor: base plus slope times raw.
          4'd0: begin
            cmd_o.acc_load = htc_pkg::LD_RH_TEMP_BASE;
            cmd_o.dt_load  = 1'b1;
            cmd_o.mul_en   = 1'b1;
            cmd_o.a_sel    = htc_pkg::A_R6_LO;
            cmd_o.b_sel    = htc_pkg::B_RAW;
            cmd_o.shift    = htc_pkg::SH_0;
          end
          4'd1: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_R6_HI;
            cmd_o.b_sel  = htc_pkg::B_RAW;
            cmd_o.shift  = htc_pkg::SH_32;
          end
          // Polynomial in raw, held 32 bits up.
          4'd3: begin
            cmd_o.f_capture = 1'b1;
            cmd_o.acc_load  = htc_pkg::LD_RH_OFFSET;
            cmd_o.mul_en    = 1'b1;
            cmd_o.a_sel     = htc_pkg::A_R3_LO;
            cmd_o.b_sel     = htc_pkg::B_RAW;
            cmd_o.shift     = htc_pkg::SH_32;
          end
          4'd4: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_R3_HI;
            cmd_o.b_sel  = htc_pkg::B_RAW;
            cmd_o.shift  = htc_pkg::SH_64;
          end
          4'd5: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_R4_LO;
            cmd_o.b_sel  = htc_pkg::B_SQ;
            cmd_o.shift  = htc_pkg::SH_32;
          end
          4'd6: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_R4_HI;
            cmd_o.b_sel  = htc_pkg::B_SQ;
            cmd_o.shift  = htc_pkg::SH_64;
          end
          // Temperature difference times the compensation factor.
          4'd7: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_DT_LO;
            cmd_o.b_sel  = htc_pkg::B_F_LO;
            cmd_o.shift  = htc_pkg::SH_0;
          end
          4'd8: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_DT_LO;
            cmd_o.b_sel  = htc_pkg::B_F_HI;
            cmd_o.shift  = htc_pkg::SH_32;
          end
          4'd9: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_DT_HI;
            cmd_o.b_sel  = htc_pkg::B_F_LO;
            cmd_o.shift  = htc_pkg::SH_32;
          end
          4'd10: begin
            cmd_o.mul_en = 1'b1;
            cmd_o.a_sel  = htc_pkg::A_DT_HI;
            cmd_o.b_sel  = htc_pkg::B_F_HI;
            cmd_o.shift  = htc_pkg::SH_64;
          end
          default: begin
          end
        endcase
      end
      htc_pkg::ST_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          unique case (job_q)
            htc_pkg::JOB_INIT: begin
              cmd_o.status  = ack_q ? htc_pkg::STAT_ACK : htc_pkg::STAT_NONE;
              cmd_o.command = htc_pkg::CMD_TEMP;
            end
            htc_pkg::JOB_TEMP: begin
              cmd_o.status    = htc_pkg::STAT_VALUE;
              cmd_o.kind      = htc_pkg::KIND_TEMP;
              cmd_o.command   = htc_pkg::CMD_RH;
              cmd_o.value_sel = htc_pkg::VAL_TEMP;
              cmd_o.lt_load   = 1'b1;
            end
            htc_pkg::JOB_HUM: begin
              cmd_o.status    = htc_pkg::STAT_VALUE;
              cmd_o.kind      = htc_pkg::KIND_RH;
              cmd_o.command   = htc_pkg::CMD_TEMP;
              cmd_o.value_sel = htc_pkg::VAL_RH;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htc_pkg::ST_IDLE;
      step_q      <= '0;
      job_q       <= htc_pkg::JOB_NONE;
      phase_q     <= htc_pkg::PH_IDLE;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      job_q       <= job_d;
      phase_q     <= phase_d;
      ack_q       <= ack_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != htc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // An accepted poll closes the input until its result is written.
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again before the result was written");

  // A delivered temperature is always followed by a humidity request.
  a_temp_then_hum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && job_q == htc_pkg::JOB_TEMP) |=> phase_q == htc_pkg::PH_HUM)
    else $error("phase did not move on to humidity");

  // A written result is presented on the next cycle.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_o && state_q == htc_pkg::ST_IDLE))
    else $error("written result not presented");
`endif

endmodule

// ===== design/humidity_temperature_compensator.sv =====
`timescale 1ns / 1ps

// Channel   | handshake                    | payload
// ----------+------------------------------+---------------------------------------
// config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
// poll in   | in_valid_i, in_stall_o       | ready_req_i, raw_reading_i, ack_i
// result out| out_valid_o, out_stall_i     | status_o, value_o, value_kind_o, command_o
//
// One poll at a time; a temperature or humidity conversion is worked out on the
// one shared 33 x 33 multiplier, which takes one partial product a cycle.
// After reset all coefficients and the stored temperature are zero and the
// first poll requests a temperature.
// A result waits in the output register while the next poll is taken; a
// conversion holds its final cycle until that register is free.
module humidity_temperature_compensator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [htc_pkg::APB_AW-1:0]       paddr,
  input  logic [htc_pkg::APB_DW-1:0]       pwdata,
  output logic [htc_pkg::APB_DW-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             ready_req_i,
  input  logic [htc_pkg::RAW_W-1:0]        raw_reading_i,
  input  logic                             ack_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [htc_pkg::VAL_W-1:0] value_o,
  output logic [1:0]                       value_kind_o,
  output logic [1:0]                       command_o
);

  htc_pkg::cfg_t    cfg;
  htc_pkg::dp_cmd_t cmd;

  // Coefficient registers.
  htc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer and handshakes.
  htc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .ready_req_i (ready_req_i),
    .ack_i       (ack_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and result register.
  htc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .raw_reading_i (raw_reading_i),
    .status_o      (status_o),
    .value_o       (value_o),
    .value_kind_o  (value_kind_o),
    .command_o     (command_o)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_COEFFS     = 7;
  localparam int UNUSED_REG_IDX = 7;
  localparam int SETTLE_CYCLES  = 20;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int PRINT_LIMIT    = 100;

  typedef logic signed [127:0] w128_t;

  typedef struct packed {
    htc_pkg::status_e  status;
    htc_pkg::value_t   value;
    htc_pkg::kind_e    kind;
    htc_pkg::command_e command;
  } poll_result_t;

  // Clock, reset and block inputs, all known from time zero.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [htc_pkg::APB_AW-1:0] paddr = '0;
  logic [htc_pkg::APB_DW-1:0] pwdata = '0;
  logic [htc_pkg::APB_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic ready_req_i = 1'b0;
  logic [htc_pkg::RAW_W-1:0] raw_reading_i = '0;
  logic ack_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic signed [htc_pkg::VAL_W-1:0] value_o;
  logic [1:0] value_kind_o;
  logic [1:0] command_o;

  // Predicted state of the compensator.
  w128_t  coeff [NUM_COEFFS] = '{default: '0};
  htc_pkg::phase_e sensor_phase = htc_pkg::PH_IDLE;
  w128_t  stored_temp = '0;

  poll_result_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_cycles = 0;

  humidity_temperature_compensator uut (.*);

  always #1 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: a long hold-off when asked for, otherwise random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic w128_t clamp_signed(input w128_t v, input int bits);
    w128_t hi_lim;
    w128_t lo_lim;
    hi_lim = (w128_t'(1) <<< (bits - 1)) - 1;
    lo_lim = -(w128_t'(1) <<< (bits - 1));
    if (v > hi_lim) return hi_lim;
    if (v < lo_lim) return lo_lim;
    return v;
  endfunction

  // Works out the result of one poll and advances the predicted state.
  function automatic poll_result_t compensate_poll(input logic rdy,
                                                   input logic [htc_pkg::RAW_W-1:0] raw,
                                                   input logic ack);
    poll_result_t r;
    w128_t raw_w, t, rh, f, dt, total, v;
    r = '0;
    raw_w = {112'd0, raw};
    case (sensor_phase)
      htc_pkg::PH_TEMP: begin
        if (rdy) begin
          t = coeff[htc_pkg::REG_TEMP_OFFSET] + coeff[htc_pkg::REG_TEMP_GAIN] * raw_w;
          stored_temp = clamp_signed(t, htc_pkg::REG_W);
          v = clamp_signed(t >>> htc_pkg::TEMP_VAL_LSB, htc_pkg::VAL_W);
          r.value = v[htc_pkg::VAL_W-1:0];
          r.status = htc_pkg::STAT_VALUE;
          r.kind = htc_pkg::KIND_TEMP;
          r.command = htc_pkg::CMD_RH;
          sensor_phase = htc_pkg::PH_HUM;
        end
      end
      htc_pkg::PH_HUM: begin
        if (rdy) begin
          rh = coeff[htc_pkg::REG_RH_OFFSET] + coeff[htc_pkg::REG_RH_LINEAR] * raw_w
               + coeff[htc_pkg::REG_RH_SQUARE] * (raw_w * raw_w);
          f = coeff[htc_pkg::REG_RH_TEMP_BASE] + coeff[htc_pkg::REG_RH_TEMP_SLOPE] * raw_w;
          dt = stored_temp - w128_t'(htc_pkg::TEMP_REF_Q32);
          total = dt * f + (rh <<< 32);
          v = clamp_signed(total >>> htc_pkg::RH_VAL_LSB, htc_pkg::VAL_W);
          r.value = v[htc_pkg::VAL_W-1:0];
          r.status = htc_pkg::STAT_VALUE;
          r.kind = htc_pkg::KIND_RH;
          r.command = htc_pkg::CMD_TEMP;
          sensor_phase = htc_pkg::PH_TEMP;
        end
      end
      default: begin
        // First poll: request a temperature and report the acknowledge.
        r.status = ack ? htc_pkg::STAT_ACK : htc_pkg::STAT_NONE;
        r.command = htc_pkg::CMD_TEMP;
        sensor_phase = htc_pkg::PH_TEMP;
      end
    endcase
    return r;
  endfunction

  // Result checker: every accepted transaction against the oldest prediction.
  always @(posedge clk_i) begin
    poll_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'({status_o, value_kind_o, command_o}), '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 64'(status_o), 64'(want.status));
        if (value_o !== want.value)
          report_mismatch("value", 64'(value_o), 64'(want.value));
        if (value_kind_o !== want.kind)
          report_mismatch("value_kind", 64'(value_kind_o), 64'(want.kind));
        if (command_o !== want.command)
          report_mismatch("command", 64'(command_o), 64'(want.command));
      end
    end
  end

  // Offers one poll, with random idle cycles first, and predicts its result.
  task automatic send_poll(input logic rdy, input logic [htc_pkg::RAW_W-1:0] raw,
                           input logic ack);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ready_req_i <= rdy;
    raw_reading_i <= raw;
    ack_i <= ack;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(compensate_poll(rdy, raw, ack));
  endtask

  // Stops offering polls and waits until every predicted result has arrived.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input int idx,
                            input logic [htc_pkg::APB_DW-1:0] wdata,
                            output logic [htc_pkg::APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= htc_pkg::APB_AW'(idx << htc_pkg::IDX_LSB);
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes one coefficient and, for a real register, reads it back; the top 16 data bits are junk.
  task automatic program_coeff(input int idx, input logic [htc_pkg::APB_DW-1:0] wdata);
    logic [htc_pkg::APB_DW-1:0] rd;
    htc_pkg::reg_t narrow;
    apb_access(1'b1, idx, wdata, rd);
    if (idx < NUM_COEFFS) begin
      narrow = wdata[htc_pkg::REG_W-1:0];
      coeff[idx] = w128_t'(narrow);
      apb_access(1'b0, idx, '0, rd);
      if (rd[htc_pkg::REG_W-1:0] !== wdata[htc_pkg::REG_W-1:0])
        report_mismatch("register readback", 64'(rd[htc_pkg::REG_W-1:0]),
                        64'(wdata[htc_pkg::REG_W-1:0]));
    end
  endtask

  function automatic logic [htc_pkg::APB_DW-1:0] pick_coeff();
    logic [63:0] r;
    int k;
    case ($urandom_range(9))
      0: r = {{16{1'b0}}, htc_pkg::REG_MAX};
      1: r = {{16{1'b1}}, htc_pkg::REG_MIN};
      2: r = '0;
      default: begin
        // Random magnitude, so that both saturated and in-range values occur.
        k = $urandom_range(46);
        r = {$urandom, $urandom} >> (63 - k);
        if ($urandom_range(1)) r = -r;
      end
    endcase
    r[63:htc_pkg::REG_W] = (64 - htc_pkg::REG_W)'($urandom);
    return r;
  endfunction

  function automatic logic [htc_pkg::RAW_W-1:0] pick_raw();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return htc_pkg::RAW_W'($urandom_range(255));
      3: return 16'hFF00 | htc_pkg::RAW_W'($urandom_range(255));
      default: return htc_pkg::RAW_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic program_all(input logic [htc_pkg::APB_DW-1:0] wdata);
    for (int i = 0; i < NUM_COEFFS; i++) program_coeff(i, wdata);
  endtask

  // First poll after reset, not-ready polls and ignored acknowledges.
  task automatic test_first_poll();
    send_poll(1'b1, 16'hFFFF, 1'b1);
    send_poll(1'b0, 16'hFFFF, 1'b1);
    send_poll(1'b1, 16'h1234, 1'b1);
    send_poll(1'b0, 16'h0000, 1'b1);
    send_poll(1'b1, 16'hABCD, 1'b0);
    wait_for_results();
  endtask

  // Every register written and read back; a write past the last one is dropped.
  task automatic test_coeff_port();
    for (int i = 0; i < NUM_COEFFS; i++) program_coeff(i, pick_coeff());
    program_coeff(UNUSED_REG_IDX, {$urandom, $urandom});
    send_poll(1'b1, pick_raw(), 1'b1);
    send_poll(1'b1, pick_raw(), 1'b0);
    wait_for_results();
  endtask

  // Largest and smallest coefficients with the raw extremes: saturation both ways.
  task automatic test_saturation_extremes();
    program_all({{16{1'b0}}, htc_pkg::REG_MAX});
    send_poll(1'b1, 16'hFFFF, 1'b0);
    send_poll(1'b1, 16'hFFFF, 1'b0);
    send_poll(1'b1, 16'h0000, 1'b1);
    send_poll(1'b1, 16'h0000, 1'b1);
    wait_for_results();
    program_all({{16{1'b1}}, htc_pkg::REG_MIN});
    send_poll(1'b1, 16'hFFFF, 1'b1);
    send_poll(1'b1, 16'hFFFF, 1'b0);
    send_poll(1'b1, 16'h0000, 1'b0);
    send_poll(1'b1, 16'h0000, 1'b1);
    wait_for_results();
  endtask

  // Coefficients near a real sensor's, so values land inside the output range.
  task automatic test_typical_coefficients();
    program_coeff(htc_pkg::REG_TEMP_OFFSET, -((longint'(396) <<< 32) / 10));
    program_coeff(htc_pkg::REG_TEMP_GAIN, (longint'(1) <<< 32) / 100);
    program_coeff(htc_pkg::REG_RH_OFFSET, -((longint'(20468) <<< 32) / 10000));
    program_coeff(htc_pkg::REG_RH_LINEAR, (longint'(367) <<< 32) / 10000);
    program_coeff(htc_pkg::REG_RH_SQUARE, -((longint'(15955) <<< 32) / 64'sd10000000000));
    program_coeff(htc_pkg::REG_RH_TEMP_BASE, (longint'(1) <<< 32) / 100);
    program_coeff(htc_pkg::REG_RH_TEMP_SLOPE, (longint'(8) <<< 32) / 100000);
    send_poll(1'b1, 16'd6400, 1'b0);
    send_poll(1'b1, 16'd1500, 1'b1);
    send_poll(1'b0, 16'd1500, 1'b1);
    send_poll(1'b1, 16'd7000, 1'b0);
    wait_for_results();
  endtask

  // Random polls, mostly ready, with fresh coefficients every few dozen.
  task automatic run_random_polls(input int count, input int send_pct, input int recv_pct);
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        wait_for_results();
        for (int i = 0; i < NUM_COEFFS; i++) program_coeff(i, pick_coeff());
      end
      send_poll($urandom_range(99) < 75, pick_raw(), 1'($urandom_range(1)));
    end
    wait_for_results();
  endtask

  // The receiver holds off while polls keep coming, so the input stalls.
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    @(posedge clk_i);
    hold_cycles = 300;
    for (int n = 0; n < 48; n++) send_poll(1'b1, pick_raw(), 1'($urandom_range(1)));
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_first_poll();
    test_coeff_port();
    test_saturation_extremes();
    test_typical_coefficients();
    run_random_polls(530, 23, 59);
    run_random_polls(530, 59, 23);
    run_random_polls(530, 0, 0);
    test_output_backpressure();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/htc_pkg.sv
design/htc_regs.sv
design/htc_dp.sv
design/htc_ctrl.sv
design/humidity_temperature_compensator.sv
tb/testbench.sv
